// File: sv/rtpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtpp_pkg
// Shared types, constants and power tables for the reduced-temperature
// power correlation pipeline.
// ----------------------------------------------------------------------------
package rtpp_pkg;

    localparam int POW_TABLE_ENTRIES = 256;
    localparam int TR_W   = 17;                           // Tr, 65536 = 1.0
    localparam int IDX_W  = $clog2(POW_TABLE_ENTRIES + 1);
    localparam int POS_W  = TR_W + IDX_W;
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = 16 / DIV_STAGES;          // quotient bits per stage

    typedef enum logic [2:0] {
        REG_COEF_P035 = 3'd0,
        REG_COEF_P23  = 3'd1,
        REG_COEF_LIN  = 3'd2,
        REG_COEF_P43  = 3'd3,
        REG_COEF_OFS  = 3'd4,
        REG_TCRIT     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EXP_P035 = 2'd0,
        EXP_P23  = 2'd1,
        EXP_P43  = 2'd2
    } pow_exp_t;

    typedef logic [TR_W-1:0] pow_tab_t [0:POW_TABLE_ENTRIES];

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v = v_in;
        res = 64'd0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 in Q.30 by repeated squaring
    function automatic logic [63:0] log2_q30(input logic [63:0] n);
        logic [63:0] m;
        logic [63:0] frac;
        int msb;
        msb = 0;
        frac = 64'd0;
        for (int j = 0; j < 62; j++) begin
            if ((n >> (j + 1)) != 64'd0) msb = j + 1;
        end
        m = (msb <= 30) ? (n << (30 - msb)) : (n >> (msb - 30));
        for (int k = 1; k <= 30; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | (64'd1 << (30 - k));
            end
        end
        return (64'(msb) << 30) + frac;
    endfunction

    function automatic pow_tab_t build_tab(input pow_exp_t sel);
        pow_tab_t    t;
        logic [63:0] hp [0:30];
        logic [63:0] ln;
        logic [63:0] li;
        logic [63:0] e;
        logic [63:0] e2;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] r;
        int          s;
        hp[0] = 64'd1 << 29;
        hp[1] = isqrt64(64'd1 << 59);
        for (int k = 2; k <= 30; k++) hp[k] = isqrt64(hp[k-1] << 30);
        ln = log2_q30(64'(POW_TABLE_ENTRIES));
        for (int i = 0; i <= POW_TABLE_ENTRIES; i++) begin
            if (i == 0) begin
                t[i] = '0;
            end else begin
                li = log2_q30(64'(i));
                e = (ln > li) ? ln - li : 64'd0;
                case (sel)
                    EXP_P035: e2 = (e * 64'd7 + 64'd10) / 64'd20;
                    EXP_P23:  e2 = (e * 64'd2 + 64'd1) / 64'd3;
                    EXP_P43:  e2 = (e * 64'd4 + 64'd1) / 64'd3;
                    default:  e2 = 64'd0;
                endcase
                n = e2 >> 30;
                f = e2 & ((64'd1 << 30) - 64'd1);
                r = 64'd1 << 30;
                for (int k = 1; k <= 30; k++) begin
                    if (((f >> (30 - k)) & 64'd1) != 64'd0)
                        r = (r * hp[k] + (64'd1 << 29)) >> 30;
                end
                if (n >= 64'd48) begin
                    t[i] = '0;
                end else begin
                    s = int'(n) + 14;
                    t[i] = TR_W'((r + (64'd1 << (s - 1))) >> s);
                end
            end
        end
        return t;
    endfunction

    localparam pow_tab_t TAB_P035 = build_tab(EXP_P035);
    localparam pow_tab_t TAB_P23  = build_tab(EXP_P23);
    localparam pow_tab_t TAB_P43  = build_tab(EXP_P43);

    function automatic logic [TR_W-1:0] pow_tab_read(input pow_exp_t sel,
                                                     input logic [IDX_W-1:0] idx);
        case (sel)
            EXP_P035: return TAB_P035[idx];
            EXP_P23:  return TAB_P23[idx];
            EXP_P43:  return TAB_P43[idx];
            default:  return '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: sv/rtpp_pow_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtpp_pow_interp
// Two-stage table lookup with linear interpolation of Tr^p over [0,1].
// ----------------------------------------------------------------------------
module rtpp_pow_interp (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire rtpp_pkg::pow_exp_t         sel,
    input  wire logic [rtpp_pkg::TR_W-1:0]  tr,
    output logic      [rtpp_pkg::TR_W-1:0]  pow
);
    import rtpp_pkg::*;

    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] idx;
    logic [TR_W-1:0]  lo_next, hi_next, lo_reg, hi_reg;
    logic [15:0]      f_reg;
    logic [TR_W-1:0]  diff;
    logic [TR_W+16:0] prod;
    logic [TR_W-1:0]  pow_next, pow_reg;

    assign pos = POS_W'(tr) * POS_W'(POW_TABLE_ENTRIES);
    // Tr <= 1.0, so the index never exceeds the last table entry
    assign idx = pos[16+IDX_W-1:16];

    always_comb begin
        if (idx >= IDX_W'(POW_TABLE_ENTRIES)) begin
            lo_next = pow_tab_read(sel, IDX_W'(POW_TABLE_ENTRIES));
            hi_next = lo_next;
        end else begin
            lo_next = pow_tab_read(sel, idx);
            hi_next = pow_tab_read(sel, idx + IDX_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            f_reg  <= pos[15:0];
        end
    end

    assign diff = hi_reg - lo_reg;
    assign prod = (TR_W+17)'(diff) * (TR_W+17)'(f_reg) + (TR_W+17)'(32768);

    always_comb begin
        if (hi_reg <= lo_reg) pow_next = lo_reg;
        else pow_next = lo_reg + prod[TR_W+15:16];
    end

    always_ff @(posedge aclk) begin
        if (en) pow_reg <= pow_next;
    end

    assign pow = pow_reg;

endmodule
`default_nettype wire

// File: sv/reduced_temperature_power_poly.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reduced_temperature_power_poly
// Liquid-density style correlation in reduced temperature, fixed point.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one beat per clock sustained while the output
// is not held. An accepted beat passes an input register, eight radix-4
// stages of the restoring divider that forms t/Tc (two quotient bits
// each), the Tr stage, two lookup/interpolation stages, a multiply stage,
// two adder stages and the round/saturate output register. The whole
// pipeline holds while the output beat waits. Configuration writes
// take effect immediately and must only be made while the pipeline is empty.
module reduced_temperature_power_poly (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [23:0]        s_temperature,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_property_value,
    output logic                    m_saturated,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import rtpp_pkg::*;

    localparam int NVLD = DIV_STAGES + 7;

    logic signed [31:0] c0_reg, c1_reg, c2_reg, c3_reg, c4_reg;
    logic [23:0]        tc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            tc_reg <= 24'd165632;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_COEF_P035: c0_reg <= cfg_data;
                REG_COEF_P23:  c1_reg <= cfg_data;
                REG_COEF_LIN:  c2_reg <= cfg_data;
                REG_COEF_P43:  c3_reg <= cfg_data;
                REG_COEF_OFS:  c4_reg <= cfg_data;
                REG_TCRIT:     tc_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // pipeline control: global hold while output is full
    logic            adv;
    logic [NVLD-1:0] vld_reg;
    logic            m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NVLD-2:0], s_valid};
            m_valid_reg <= vld_reg[NVLD-1];
        end
    end

    // divider: rem < Tc is kept, quotient grows two bits per stage
    logic [23:0] rem_reg [0:DIV_STAGES];
    logic [15:0] quo_reg [0:DIV_STAGES];
    logic        zero_reg [0:DIV_STAGES];
    logic        zero_in;

    assign zero_in = (tc_reg == 24'd0) || (s_temperature >= tc_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= zero_in ? 24'd0 : s_temperature;
            quo_reg[0]  <= '0;
            zero_reg[0] <= zero_in;
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        logic [23:0] rem_next;
        logic [15:0] quo_next;
        logic [24:0] sh;
        always_comb begin
            rem_next = rem_reg[g];
            quo_next = quo_reg[g];
            sh = '0;
            for (int b = 0; b < DIV_BITS; b++) begin
                sh = {rem_next, 1'b0};
                if (sh >= {1'b0, tc_reg}) begin
                    sh = sh - {1'b0, tc_reg};
                    quo_next = {quo_next[14:0], 1'b1};
                end else begin
                    quo_next = {quo_next[14:0], 1'b0};
                end
                rem_next = sh[23:0];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[g+1]  <= rem_next;
                quo_reg[g+1]  <= quo_next;
                zero_reg[g+1] <= zero_reg[g];
            end
        end
    end

    logic [TR_W-1:0] tr_reg, tr_d1_reg, tr_d2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            tr_reg    <= zero_reg[DIV_STAGES] ? '0
                         : TR_W'(17'h10000) - TR_W'(quo_reg[DIV_STAGES]);
            tr_d1_reg <= tr_reg;
            tr_d2_reg <= tr_d1_reg;
        end
    end

    logic [TR_W-1:0] pw35, pw23, pw43;

    rtpp_pow_interp u_p035 (.aclk(aclk), .en(adv), .sel(EXP_P035), .tr(tr_reg), .pow(pw35));
    rtpp_pow_interp u_p23  (.aclk(aclk), .en(adv), .sel(EXP_P23),  .tr(tr_reg), .pow(pw23));
    rtpp_pow_interp u_p43  (.aclk(aclk), .en(adv), .sel(EXP_P43),  .tr(tr_reg), .pow(pw43));

    logic signed [49:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [50:0] s01_reg, s23_reg;
    logic signed [51:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_reg  <= 50'(c0_reg) * 50'(signed'({1'b0, pw35}));
            p1_reg  <= 50'(c1_reg) * 50'(signed'({1'b0, pw23}));
            p2_reg  <= 50'(c2_reg) * 50'(signed'({1'b0, tr_d2_reg}));
            p3_reg  <= 50'(c3_reg) * 50'(signed'({1'b0, pw43}));
            s01_reg <= 51'(p0_reg) + 51'(p1_reg);
            s23_reg <= 51'(p2_reg) + 51'(p3_reg);
            sum_reg <= 52'(s01_reg) + 52'(s23_reg) + (52'(c4_reg) <<< 16);
        end
    end

    // round half up, then clip to 32 bits
    logic signed [51:0] rnd;
    logic signed [35:0] res;
    logic signed [31:0] val_next;
    logic               sat_next;
    logic signed [31:0] val_reg;
    logic               sat_reg;

    assign rnd = (sum_reg + 52'sd32768) >>> 16;
    assign res = rnd[35:0];

    always_comb begin
        if (res > 36'sh07FFFFFFF) begin
            val_next = 32'sh7FFFFFFF;
            sat_next = 1'b1;
        end else if (res < -36'sh080000000) begin
            val_next = 32'sh80000000;
            sat_next = 1'b1;
        end else begin
            val_next = res[31:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            val_reg <= val_next;
            sat_reg <= sat_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_property_value = val_reg;
    assign m_saturated      = sat_reg;

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_property_value == 32'sh7FFFFFFF || m_property_value == 32'sh80000000))
        else $error("saturation flag without clipped value");

    a_hold_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("pipeline held without a waiting output beat");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

endmodule
`default_nettype wire
